### rtl/swr_pkg.sv
// Package for the stratified weight resampler: shared state type.
// No dependencies.
`default_nettype none
package swr_pkg;
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_DIV,
        ST_WALK,
        ST_EMIT
    } state_t;
endpackage
`default_nettype wire

### rtl/swr_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing.
`default_nettype none
module swr_div #(
    parameter int NUM_W = 45,
    parameter int DEN_W = 22
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [NUM_W-1:0]      quot
);
    localparam int CW = $clog2(NUM_W + 1);
    logic [NUM_W-1:0] q_reg;
    logic [DEN_W:0]   r_reg;
    logic [DEN_W-1:0] d_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W+1:0] diff;

    assign trial = {r_reg[DEN_W-1:0], q_reg[NUM_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            // pulse done after the last quotient bit
            done_reg <= !start && busy_reg && (cnt_reg == CW'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end else if (busy_reg) begin
            if (!diff[DEN_W+1]) begin
                r_reg <= diff[DEN_W:0];
                q_reg <= {q_reg[NUM_W-2:0], 1'b1};
            end else begin
                r_reg <= trial;
                q_reg <= {q_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule
`default_nettype wire

### rtl/stratified_weight_resampler_top.sv
// Top level of the stratified weight resampler.
// Depends on swr_pkg and swr_div.
//
// Weights load at one word per cycle. On the word marked tlast the block
// drops s_axis_tready and, for each stored weight, runs the shared
// bit-serial divider for 23+FRAC_BITS quotient bits. Each division is
// followed by a walk that takes one unit off the carry per emitted
// index (including those dropped once m are out) before the next weight.
// Then the slot read is primed and the m slots stream out at one
// word per cycle while m_axis_tready stays high. A zero weight sum or
// count skips the divisions and goes to the output with m_axis_tuser set.
`default_nettype none
module stratified_weight_resampler_top
    import swr_pkg::*;
#(
    parameter int MAX_PARTICLES = 64,
    parameter int FRAC_BITS     = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [6:0]  cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // weight[15:0], rand_frac[31:16]
    input  wire logic        s_axis_tlast,  // last_weight
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // particle_index[6:0], zero[7]
    output logic             m_axis_tuser,  // sum_error
    output logic             m_axis_tlast   // last_index
);
    localparam int AW    = $clog2(MAX_PARTICLES);
    localparam int NUM_W = 23 + FRAC_BITS;
    localparam int CW    = FRAC_BITS + 9;   // signed carry width
    localparam int RAND_UP   = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int RAND_DOWN = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam logic [6:0] MAXP = 7'(MAX_PARTICLES);

    state_t state_reg, state_next;
    logic [6:0]  out_count_reg;
    logic [21:0] sum_reg;
    logic [6:0]  n_reg;         // fill count
    logic [6:0]  m_reg;
    logic [6:0]  i_reg;         // weight being walked
    logic [6:0]  k_reg;         // emit count
    logic [6:0]  largest_reg;
    logic [6:0]  o_reg;         // output slot
    logic [CW-1:0] c_reg;
    logic          err_reg;
    logic [6:0]  slot_mem [MAX_PARTICLES];
    logic [15:0] wmem [MAX_PARTICLES];
    logic [15:0] rmem [MAX_PARTICLES];
    logic [MAX_PARTICLES-1:0] rvalid_reg;
    logic [15:0] w_rd_reg;
    logic [15:0] rand_rd_reg;
    logic [6:0]  slot_rd_reg;
    logic        rd_ok_reg;
    logic        div_start_reg;
    logic        div_done;
    logic [NUM_W-1:0] quot;
    logic [22:0] w_times_m;
    logic        acc;
    logic [6:0]  n_new;
    logic [21:0] sum_new;
    logic [6:0]  m_calc;
    logic [6:0]  i_next;
    logic [6:0]  k_next;
    logic        rand_ok;
    logic [CW-1:0] rand_fx;
    logic [CW-1:0] c_sub;
    logic        ge_one, ge_rand, walk_emit;

    assign acc     = s_axis_tvalid && s_axis_tready;
    assign n_new   = (n_reg < MAXP) ? n_reg + 7'd1 : n_reg;
    assign sum_new = (n_reg < MAXP) ? sum_reg + 22'(s_axis_tdata[15:0]) : sum_reg;
    always_comb begin
        m_calc = (out_count_reg == 7'd0) ? n_new : out_count_reg;
        if (m_calc > MAXP) m_calc = MAXP;
    end

    // random threshold for the current emit count
    always_comb begin
        rand_ok = (k_reg < MAXP) && rvalid_reg[k_reg[AW-1:0]];
        rand_fx = rand_ok ? ((CW'(rand_rd_reg) << RAND_UP) >> RAND_DOWN) : '0;
    end

    assign ge_one    = !c_reg[CW-1] && (c_reg[CW-2:FRAC_BITS] != '0);
    assign c_sub     = c_reg - (CW'(1) << FRAC_BITS);
    assign ge_rand   = !c_reg[CW-1] && (c_reg >= rand_fx);
    assign walk_emit = ge_one || (k_reg < m_reg && ge_rand);

    // next walk and emit positions, used as memory read addresses
    always_comb begin
        i_next = i_reg;
        k_next = k_reg;
        if (state_reg == ST_LOAD && acc && s_axis_tlast) begin
            i_next = '0;
            k_next = '0;
        end else if (state_reg == ST_WALK) begin
            if (!walk_emit) i_next = i_reg + 7'd1;
            else if (k_reg < m_reg) k_next = k_reg + 7'd1;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: if (acc && s_axis_tlast)
                state_next = (sum_new == 22'd0 || n_new == 7'd0) ? ST_EMIT : ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_WALK;
            ST_WALK: if (!walk_emit) state_next = (i_reg + 7'd1 >= n_reg) ? ST_EMIT : ST_DIV;
            ST_EMIT: if (m_reg == 7'd0 || (m_axis_tvalid && m_axis_tready && m_axis_tlast))
                state_next = ST_LOAD;
            default: state_next = ST_LOAD;
        endcase
    end

    always_comb begin
        s_axis_tready = (state_reg == ST_LOAD);
    end

    assign w_times_m = 23'(w_rd_reg) * 23'(m_reg);

    swr_div #(.NUM_W(NUM_W), .DEN_W(22)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start_reg),
        .num({w_times_m, {FRAC_BITS{1'b0}}}),
        .den(sum_reg), .done(div_done), .quot(quot)
    );

    always_ff @(posedge aclk) begin
        if (acc && n_reg < MAXP) begin
            wmem[n_reg[AW-1:0]] <= s_axis_tdata[15:0];
            rmem[n_reg[AW-1:0]] <= s_axis_tdata[31:16];
        end
        // pass a weight written in this same cycle straight through
        if (acc && n_reg < MAXP && n_reg[AW-1:0] == i_next[AW-1:0])
            w_rd_reg <= s_axis_tdata[15:0];
        else
            w_rd_reg <= wmem[i_next[AW-1:0]];
        rand_rd_reg <= rmem[k_next[AW-1:0]];
        if (state_reg == ST_WALK && walk_emit && k_reg < m_reg)
            slot_mem[k_reg[AW-1:0]] <= i_reg + 7'd1;
        // hold the shown slot while stalled
        if (state_reg == ST_EMIT && (!rd_ok_reg || m_axis_tready))
            slot_rd_reg <= slot_mem[o_reg[AW-1:0]];
        if (state_reg == ST_DIV && div_done) c_reg <= c_reg + CW'(quot);
        else if (state_reg == ST_WALK && walk_emit) c_reg <= c_sub;
        else if (state_reg == ST_LOAD) c_reg <= '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            out_count_reg <= 7'd0;
            sum_reg       <= '0;
            n_reg <= '0; m_reg <= '0; i_reg <= '0; k_reg <= '0; o_reg <= '0;
            largest_reg   <= '0;
            err_reg       <= 1'b0;
            rvalid_reg    <= '0;
            div_start_reg <= 1'b0;
            rd_ok_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            div_start_reg <= (state_next == ST_DIV) && (state_reg != ST_DIV);
            if (cfg_we) out_count_reg <= cfg_wdata;
            case (state_reg)
                ST_LOAD: begin
                    if (acc) begin
                        if (n_reg < MAXP) begin
                            rvalid_reg[n_reg[AW-1:0]] <= 1'b1;
                            sum_reg <= sum_new;
                        end
                        n_reg <= n_new;
                        if (s_axis_tlast) begin
                            m_reg <= m_calc;
                            i_reg <= '0; k_reg <= '0; o_reg <= '0;
                            largest_reg <= '0;
                            rd_ok_reg <= 1'b0;
                            err_reg <= (state_next == ST_EMIT);
                        end
                    end
                end
                ST_DIV: ;
                ST_WALK: begin
                    if (walk_emit) begin
                        if (k_reg < m_reg) begin
                            k_reg <= k_reg + 7'd1;
                            largest_reg <= i_reg + 7'd1;
                        end
                    end else begin
                        i_reg <= i_reg + 7'd1;
                    end
                end
                ST_EMIT: begin
                    if (!rd_ok_reg || m_axis_tready) o_reg <= o_reg + 7'd1;
                    if (state_next == ST_LOAD) begin
                        n_reg <= '0; sum_reg <= '0; rvalid_reg <= '0;
                        rd_ok_reg <= 1'b0;
                    end else if (!rd_ok_reg) begin
                        rd_ok_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // out slot being shown is o_reg-1; slot_rd_reg holds it
    logic [6:0] shown;
    logic       is_last;
    assign shown   = o_reg - 7'd1;
    assign is_last = (o_reg == m_reg);
    // drive the output word from the shown slot; it is held while stalled
    always_comb begin
        m_axis_tvalid = (state_reg == ST_EMIT) && rd_ok_reg && m_reg != 7'd0;
        m_axis_tlast  = is_last;
        m_axis_tuser  = err_reg;
        m_axis_tdata  = 8'd0;
        if (!err_reg) begin
            if (shown < k_reg)      m_axis_tdata = {1'b0, slot_rd_reg};
            else if (is_last)       m_axis_tdata = {1'b0, largest_reg};
        end
    end
endmodule
`default_nettype wire

### rtl/swr_checker.sv
// Port-level checker for the stratified weight resampler.
// Depends on stratified_weight_resampler_top ports only.
`default_nettype none
module swr_port_props (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic       m_axis_tlast,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tuser
);
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready) else $error("input open during draw");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable({m_axis_tlast, m_axis_tuser, m_axis_tdata}))
        else $error("word dropped");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'd0) else $error("error word nonzero");
    a_top_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !m_axis_tdata[7]) else $error("pad bit set");
endmodule

bind stratified_weight_resampler_top swr_port_props u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tlast(m_axis_tlast), .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
`default_nettype wire
